// File: hdl/iae_pkg.sv
// ----------------------------------------------------------------------------
// iae_pkg: shared types and codes for the indexed array engine
// Operation codes, status codes, slot width and the ring control struct.
// ----------------------------------------------------------------------------
package iae_pkg;

   localparam int SLOT_W   = 32;
   localparam int FUNC_W   = 3;
   localparam int STATUS_W = 2;

   localparam logic [FUNC_W-1:0] FUNC_REPLACE = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_INSERT  = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_DELETE  = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_SWAP    = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_FIND    = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_IDX = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;

   // control from the sequencer to the ring of slot cells
   typedef struct packed {
      logic              shift;   // all cells move one place toward the head
      logic [SLOT_W-1:0] wdata;   // value entering the tail cell
   } chain_ctl_type;

endpackage

// File: hdl/iae_req_if.sv
// ----------------------------------------------------------------------------
// iae_req_if: request channel
// valid/ready handshake carrying one operation request.
// ----------------------------------------------------------------------------
interface iae_req_if
   import iae_pkg::*;
   #(parameter int DEPTH = 64)
   ();

   localparam int CW = $clog2(DEPTH + 1);
   localparam int AW = $clog2(DEPTH);

   logic                     valid;
   logic                     ready;
   logic [FUNC_W-1:0]        func;
   logic signed [SLOT_W-1:0] value;
   logic [CW-1:0]            index_a;
   logic [AW-1:0]            index_b;

   modport source (output valid, func, value, index_a, index_b, input ready);
   modport sink   (input valid, func, value, index_a, index_b, output ready);

endinterface

// File: hdl/iae_rsp_if.sv
// ----------------------------------------------------------------------------
// iae_rsp_if: response channel
// valid/ready handshake carrying one result per request.
// ----------------------------------------------------------------------------
interface iae_rsp_if
   import iae_pkg::*;
   #(parameter int DEPTH = 64)
   ();

   localparam int CW = $clog2(DEPTH + 1);
   localparam int AW = $clog2(DEPTH);

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic                found;
   logic [AW-1:0]       position;
   logic [CW-1:0]       count_out;

   modport source (output valid, status, found, position, count_out, input ready);
   modport sink   (input valid, status, found, position, count_out, output ready);

endinterface

// File: hdl/iae_cell.sv
// ----------------------------------------------------------------------------
// iae_cell: one slot of the ring
// Holds one value; on shift it takes the value of its upstream neighbor.
// ----------------------------------------------------------------------------
module iae_cell
   import iae_pkg::*;
   (
   input  logic              clock,
   input  logic              shift,
   input  logic [SLOT_W-1:0] d_in,
   output logic [SLOT_W-1:0] q_out
   );

   logic [SLOT_W-1:0] slot_ff;
   logic [SLOT_W-1:0] slot_in;

   assign slot_in = shift ? d_in : slot_ff;
   assign q_out   = slot_ff;

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

endmodule

// File: hdl/iae_ctrl.sv
// ----------------------------------------------------------------------------
// iae_ctrl: request sequencer
// Checks each request, drives ring rotations, edits values at the head,
// keeps the element count and registers the response.
// ----------------------------------------------------------------------------
module iae_ctrl
   import iae_pkg::*;
   #(parameter int DEPTH = 64)
   (
   input  logic              clock,
   input  logic              reset,
   iae_req_if.sink           req_bus,
   iae_rsp_if.source         rsp_bus,
   input  logic [SLOT_W-1:0] head,
   input  logic [SLOT_W-1:0] next_slot,
   output chain_ctl_type     ctl
   );

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
   localparam logic [AW-1:0] LAST_STEP  = AW'(DEPTH - 1);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;   // swap: capture both slots
   localparam logic [1:0] ST_ROTATE = 2'd2;   // edit pass
   localparam logic [1:0] ST_DONE   = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [AW-1:0]       step_ff, step_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [FUNC_W-1:0]   func_ff, func_in;
   logic [SLOT_W-1:0]   value_ff, value_in;
   logic [CW-1:0]       ia_ff, ia_in;
   logic [AW-1:0]       ib_ff, ib_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic                found_ff, found_in;
   logic [AW-1:0]       pos_ff, pos_in;
   logic [SLOT_W-1:0]   cap_a_ff, cap_a_in;
   logic [SLOT_W-1:0]   cap_b_ff, cap_b_in;
   logic [SLOT_W-1:0]   carry_ff, carry_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic                rsp_found_ff, rsp_found_in;
   logic [AW-1:0]       rsp_pos_ff, rsp_pos_in;
   logic [CW-1:0]       rsp_count_ff, rsp_count_in;

   logic                accept;
   logic [CW-1:0]       step_ext;
   logic                last_step;
   logic                ia_in_use;
   logic                ib_in_use;
   logic [STATUS_W-1:0] chk_status;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;
   assign step_ext      = CW'(step_ff);
   assign last_step     = (step_ff == LAST_STEP);
   assign ia_in_use     = (req_bus.index_a < count_ff);
   assign ib_in_use     = (CW'(req_bus.index_b) < count_ff);

   // request check against the current count
   always_comb begin
      unique case (req_bus.func)
         FUNC_REPLACE: chk_status = ia_in_use ? STATUS_OK : STATUS_BAD_IDX;
         FUNC_INSERT: begin
            if (count_ff == FULL_COUNT) chk_status = STATUS_FULL;
            else if (req_bus.index_a > count_ff) chk_status = STATUS_BAD_IDX;
            else chk_status = STATUS_OK;
         end
         FUNC_DELETE: chk_status = ia_in_use ? STATUS_OK : STATUS_BAD_IDX;
         FUNC_SWAP:   chk_status = (ia_in_use && ib_in_use) ? STATUS_OK : STATUS_BAD_IDX;
         FUNC_FIND:   chk_status = STATUS_OK;
         default:     chk_status = STATUS_BAD_IDX;
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      count_in      = count_ff;
      func_in       = func_ff;
      value_in      = value_ff;
      ia_in         = ia_ff;
      ib_in         = ib_ff;
      status_in     = status_ff;
      found_in      = found_ff;
      pos_in        = pos_ff;
      cap_a_in      = cap_a_ff;
      cap_b_in      = cap_b_ff;
      carry_in      = carry_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_count_in  = rsp_count_ff;
      ctl.shift     = 1'b0;
      ctl.wdata     = head;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               func_in   = req_bus.func;
               value_in  = req_bus.value;
               ia_in     = req_bus.index_a;
               ib_in     = req_bus.index_b;
               status_in = chk_status;
               found_in  = 1'b0;
               pos_in    = '0;
               step_in   = '0;
               if (chk_status != STATUS_OK) state_in = ST_DONE;
               else if (req_bus.func == FUNC_SWAP) state_in = ST_SCAN;
               else state_in = ST_ROTATE;
            end
         end
         ST_SCAN: begin
            ctl.shift = 1'b1;
            if (step_ext == ia_ff) cap_a_in = head;
            if (step_ff == ib_ff) cap_b_in = head;
            if (last_step) begin
               step_in  = '0;
               state_in = ST_ROTATE;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_ROTATE: begin
            ctl.shift = 1'b1;
            unique case (func_ff)
               FUNC_REPLACE: if (step_ext == ia_ff) ctl.wdata = value_ff;
               FUNC_INSERT: begin
                  // values at or past the index slide up through the carry
                  if (step_ext == ia_ff) begin
                     ctl.wdata = value_ff;
                     carry_in  = head;
                  end else if (step_ext > ia_ff) begin
                     ctl.wdata = carry_ff;
                     carry_in  = head;
                  end
               end
               FUNC_DELETE: if (step_ext >= ia_ff) ctl.wdata = next_slot;
               FUNC_SWAP: begin
                  if (step_ext == ia_ff) ctl.wdata = cap_b_ff;
                  else if (step_ff == ib_ff) ctl.wdata = cap_a_ff;
               end
               FUNC_FIND: begin
                  if (!found_ff && (step_ext < count_ff) && (head == value_ff)) begin
                     found_in = 1'b1;
                     pos_in   = step_ff;
                  end
               end
               default: ctl.wdata = head;
            endcase
            if (last_step) begin
               step_in  = '0;
               state_in = ST_DONE;
               if (func_ff == FUNC_INSERT) count_in = count_ff + 1'b1;
               else if (func_ff == FUNC_DELETE) count_in = count_ff - 1'b1;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_found_in  = found_ff;
               rsp_pos_in    = pos_ff;
               rsp_count_in  = count_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      value_ff      <= value_in;
      ia_ff         <= ia_in;
      ib_ff         <= ib_in;
      status_ff     <= status_in;
      found_ff      <= found_in;
      pos_ff        <= pos_in;
      cap_a_ff      <= cap_a_in;
      cap_b_ff      <= cap_b_in;
      carry_ff      <= carry_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.status    = rsp_status_ff;
   assign rsp_bus.found     = rsp_found_ff;
   assign rsp_bus.position  = rsp_pos_ff;
   assign rsp_bus.count_out = rsp_count_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("element count above depth");

   a_rotate_from_zero: assert property (@(posedge clock) disable iff (reset)
      (accept && chk_status == STATUS_OK) |=> (step_ff == '0))
      else $error("rotation does not start at the head");

   a_found_in_use: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && found_ff) |-> (CW'(pos_ff) < count_ff))
      else $error("match reported beyond the used elements");

   a_found_only_find: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && found_ff) |-> (func_ff == FUNC_FIND))
      else $error("found flag set for a non-find request");

   a_bad_no_change: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && status_ff != STATUS_OK) |-> $stable(count_ff))
      else $error("rejected request changed the count");
`endif

endmodule

// File: hdl/indexed_array_engine.sv
// ----------------------------------------------------------------------------
// indexed_array_engine: ordered array with insert, delete, swap and find
// Top level: ring of slot cells plus the request sequencer.
// ----------------------------------------------------------------------------
// Usage:
//  - req_bus carries one request (func, value, index_a, index_b); it is taken
//    at a clock edge with valid and ready both high. ready is high only while
//    no request is in progress.
//  - rsp_bus returns exactly one response per request (status, found,
//    position, count_out), held in an output register until taken.
//  - The DEPTH slots form a ring of cells. Every accepted, valid request
//    rotates the whole ring once (swap twice: one pass to capture both
//    slots, one to write), one cell per cycle, and edits values as they
//    pass the head cell; the ring ends in its original order.
//  - A rejected request goes straight to its final step; replace, insert,
//    delete and find make one pass of the ring before the response is
//    loaded. The next request is taken the cycle after the response is
//    loaded, so a new request is never taken before the last one's ring
//    rotation and response are done.
//  - Reset clears the element count and the response valid; slot contents
//    are not cleared and are only ever read below the count.
//  - If rsp_bus stalls, a finished request waits in its final step until
//    the output register frees up; no further request is taken meanwhile.
// ----------------------------------------------------------------------------
module indexed_array_engine
   import iae_pkg::*;
   #(parameter int DEPTH = 64)
   (
   input  logic      clock,
   input  logic      reset,
   iae_req_if.sink   req_bus,
   iae_rsp_if.source rsp_bus
   );

   // cell outputs; index 0 is the head seen by the sequencer
   logic [SLOT_W-1:0] cell_q [DEPTH];
   chain_ctl_type     ctl;

   iae_ctrl #(.DEPTH(DEPTH)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .head      (cell_q[0]),
      .next_slot (cell_q[1]),
      .ctl       (ctl)
   );

   // each cell takes its upstream neighbor; the tail takes the edited value
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      if (i == DEPTH - 1) begin : g_tail
         iae_cell u_cell (
            .clock (clock),
            .shift (ctl.shift),
            .d_in  (ctl.wdata),
            .q_out (cell_q[i])
         );
      end else begin : g_body
         iae_cell u_cell (
            .clock (clock),
            .shift (ctl.shift),
            .d_in  (cell_q[i+1]),
            .q_out (cell_q[i])
         );
      end
   end

endmodule
